// ----- rtl/lbm_pkg.sv -----
// shared types, constants and helper functions for the d2q9 bgk collision block
// no dependencies; every other file imports this package
`default_nettype none

package lbm_pkg;

  // number format
  localparam int DW = 16;
  localparam int FB = 14;
  localparam int NDIR = 9;

  // internal widths
  localparam int SW  = 2 * DW + 8;   // wide signed work width before saturation
  localparam int SQW = 2 * DW - FB;  // width of a squared velocity after scaling
  localparam int TW  = 2 * DW - FB;  // width of rho * p after scaling
  localparam int MW  = TW + 3;       // magnitude of t times the weight numerator
  localparam int RK  = MW + 6;       // reciprocal shift for the weight divide
  localparam int RCW = RK - 2;       // reciprocal width

  // pipeline depths
  localparam int DIV_LAT  = DW + 2;
  localparam int FEQ_LAT  = 8;
  localparam int PIPE_LAT = 1 + DIV_LAT + FEQ_LAT;

  // configuration port
  localparam int AW = 4;
  localparam int PDW = 32;
  localparam logic [1:0] REG_RELAX     = 2'd0;
  localparam logic [1:0] REG_INLET_RHO = 2'd1;
  localparam logic [1:0] REG_INLET_VEL = 2'd2;

  localparam logic [DW-2:0] RELAX_RST     = (DW-1)'(16384);
  localparam logic [DW-2:0] INLET_RHO_RST = (DW-1)'(16384);
  localparam logic [DW-1:0] INLET_VEL_RST = DW'(1638);

  // cell kinds
  localparam logic [1:0] KIND_FLUID = 2'd0;
  localparam logic [1:0] KIND_SOLID = 2'd1;
  localparam logic [1:0] KIND_INLET = 2'd2;

  // reciprocals for the weight denominators, rounded up
  localparam longint unsigned RECIP9_L  = ((64'd1 << RK) + 64'd8) / 64'd9;
  localparam longint unsigned RECIP36_L = ((64'd1 << RK) + 64'd35) / 64'd36;
  localparam logic [RCW-1:0] RECIP9  = RCW'(RECIP9_L);
  localparam logic [RCW-1:0] RECIP36 = RCW'(RECIP36_L);

  localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (DW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);
  localparam logic signed [SW-1:0] ONE_W  = SW'(64'sd1 <<< FB);

  typedef logic signed [DW-1:0] dist_t;
  typedef dist_t dist_arr_t [NDIR];

  typedef struct packed {
    dist_t      dist_0;
    dist_t      dist_1;
    dist_t      dist_2;
    dist_t      dist_3;
    dist_t      dist_4;
    dist_t      dist_5;
    dist_t      dist_6;
    dist_t      dist_7;
    dist_t      dist_8;
    logic [1:0] cell_kind;
  } in_item_t;

  typedef struct packed {
    dist_t post_0;
    dist_t post_1;
    dist_t post_2;
    dist_t post_3;
    dist_t post_4;
    dist_t post_5;
    dist_t post_6;
    dist_t post_7;
    dist_t post_8;
    logic  density_fault;
  } out_item_t;

  // moments of one cell plus its control bits
  typedef struct packed {
    dist_t      rho;
    dist_t      jx;
    dist_t      jy;
    logic       fault;
    logic [1:0] kind;
  } mom_t;

  typedef struct packed {
    logic [DW-2:0] relax_rate;
    logic [DW-2:0] inlet_density;
    dist_t         inlet_velocity;
  } cfg_t;

  // lattice directions: rest, +x, +y, -x, -y, +x+y, -x+y, -x-y, +x-y
  function automatic logic signed [1:0] dir_x(input int i);
    unique case (i)
      1, 5, 8: dir_x = 2'sd1;
      3, 6, 7: dir_x = -2'sd1;
      default: dir_x = 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] dir_y(input int i);
    unique case (i)
      2, 5, 6: dir_y = 2'sd1;
      4, 7, 8: dir_y = -2'sd1;
      default: dir_y = 2'sd0;
    endcase
  endfunction

  // rest weight has numerator four, diagonals divide by 36
  function automatic logic is_rest(input int i);
    is_rest = (i == 0);
  endfunction

  function automatic logic is_diag(input int i);
    is_diag = (i >= 5);
  endfunction

  function automatic dist_t sat(input logic signed [SW-1:0] x);
    if (x > SAT_HI) begin
      sat = SAT_HI[DW-1:0];
    end else if (x < SAT_LO) begin
      sat = SAT_LO[DW-1:0];
    end else begin
      sat = x[DW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/lbm_apb.sv -----
// configuration registers behind an apb-style port
// depends on lbm_pkg
`default_nettype none

module lbm_apb
  import lbm_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [AW-1:0]  paddr,
  input  wire logic [PDW-1:0] pwdata,
  output logic      [PDW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t       cfg_q;
  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.relax_rate     <= RELAX_RST;
      cfg_q.inlet_density  <= INLET_RHO_RST;
      cfg_q.inlet_velocity <= INLET_VEL_RST;
    end else if (wr) begin
      unique case (idx)
        REG_RELAX:     cfg_q.relax_rate     <= pwdata[DW-2:0];
        REG_INLET_RHO: cfg_q.inlet_density  <= pwdata[DW-2:0];
        REG_INLET_VEL: cfg_q.inlet_velocity <= pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_RELAX:     prdata = PDW'(cfg_q.relax_rate);
      REG_INLET_RHO: prdata = PDW'(cfg_q.inlet_density);
      REG_INLET_VEL: prdata = PDW'(cfg_q.inlet_velocity);
      default:       prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/lbm_moments.sv -----
// first stage: density and momentum sums of one cell, saturated and registered
// depends on lbm_pkg
`default_nettype none

module lbm_moments
  import lbm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic en_i,
  input  in_item_t  in_data_i,
  output mom_t      mom_o,
  output dist_arr_t f_o
);

  dist_arr_t               f_in;
  dist_arr_t               f_q;
  mom_t                    mom_q;
  logic signed [SW-1:0]    rsum;
  logic signed [SW-1:0]    jxs;
  logic signed [SW-1:0]    jys;
  dist_t                   rho_s;

  assign f_in[0] = in_data_i.dist_0;
  assign f_in[1] = in_data_i.dist_1;
  assign f_in[2] = in_data_i.dist_2;
  assign f_in[3] = in_data_i.dist_3;
  assign f_in[4] = in_data_i.dist_4;
  assign f_in[5] = in_data_i.dist_5;
  assign f_in[6] = in_data_i.dist_6;
  assign f_in[7] = in_data_i.dist_7;
  assign f_in[8] = in_data_i.dist_8;

  // exact sums over the nine directions
  always_comb begin
    rsum = '0;
    jxs  = '0;
    jys  = '0;
    for (int i = 0; i < NDIR; i++) begin
      rsum = rsum + SW'(f_in[i]);
      if (dir_x(i) == 2'sd1) begin
        jxs = jxs + SW'(f_in[i]);
      end else if (dir_x(i) == -2'sd1) begin
        jxs = jxs - SW'(f_in[i]);
      end
      if (dir_y(i) == 2'sd1) begin
        jys = jys + SW'(f_in[i]);
      end else if (dir_y(i) == -2'sd1) begin
        jys = jys - SW'(f_in[i]);
      end
    end
  end

  assign rho_s = sat(rsum);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mom_q.rho   <= rho_s;
      mom_q.jx    <= sat(jxs);
      mom_q.jy    <= sat(jys);
      mom_q.fault <= (rho_s <= 0);
      mom_q.kind  <= in_data_i.cell_kind;
      f_q         <= f_in;
    end
  end

  assign mom_o = mom_q;
  assign f_o   = f_q;

endmodule

`default_nettype wire

// ----- rtl/lbm_div.sv -----
// pipelined restoring divider: sat(num * 2^FB / den), truncated toward zero
// one quotient bit per stage; depends on lbm_pkg
`default_nettype none

module lbm_div
  import lbm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic en_i,
  input  dist_t     num_i,
  input  dist_t     den_i,
  output dist_t     quo_o
);

  localparam int NW = DW + FB;

  logic [DW-1:0] mag;
  logic [NW-1:0] nval;
  logic          ovf;

  logic [DW-2:0] rem_q [DW+1];
  logic [DW-1:0] low_q [DW+1];
  logic [DW-1:0] q_q   [DW+1];
  logic [DW-2:0] d_q   [DW+1];
  logic          neg_q [DW+1];
  logic          ovf_q [DW+1];
  dist_t         quo_q;

  // magnitude of the scaled dividend and the early overflow test
  assign mag  = num_i[DW-1] ? (~num_i + DW'(1)) : num_i;
  assign nval = {mag, {FB{1'b0}}};
  assign ovf  = (NW + DW)'(nval) >= (NW + DW)'({den_i[DW-2:0], {DW{1'b0}}});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= (DW-1)'(nval[NW-1:DW]);
      low_q[0] <= nval[DW-1:0];
      q_q[0]   <= '0;
      d_q[0]   <= den_i[DW-2:0];
      neg_q[0] <= num_i[DW-1];
      ovf_q[0] <= ovf;
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= DW; k++) begin : g_step
    logic [DW-1:0] tr;
    logic          ge;
    assign tr = {rem_q[k-1], low_q[k-1][DW-1]};
    assign ge = tr >= {1'b0, d_q[k-1]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? (DW-1)'(tr - {1'b0, d_q[k-1]}) : tr[DW-2:0];
        low_q[k] <= {low_q[k-1][DW-2:0], 1'b0};
        q_q[k]   <= {q_q[k-1][DW-2:0], ge};
        d_q[k]   <= d_q[k-1];
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  // sign and saturation
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (neg_q[DW]) begin
        if (ovf_q[DW] || (q_q[DW] > {1'b1, {(DW-1){1'b0}}})) begin
          quo_q <= SAT_LO[DW-1:0];
        end else begin
          quo_q <= ~q_q[DW] + DW'(1);
        end
      end else begin
        if (ovf_q[DW] || q_q[DW][DW-1]) begin
          quo_q <= SAT_HI[DW-1:0];
        end else begin
          quo_q <= q_q[DW];
        end
      end
    end
  end

  assign quo_o = quo_q;

endmodule

`default_nettype wire

// ----- rtl/lbm_feq.sv -----
// equilibrium and bgk relaxation for nine directions, eight register stages
// the last stage is the output register; depends on lbm_pkg
`default_nettype none

module lbm_feq
  import lbm_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  dist_t              r_i,
  input  dist_t              ux_i,
  input  dist_t              uy_i,
  input  wire logic [1:0]    kind_i,
  input  wire logic          fault_i,
  input  dist_arr_t          f_i,
  input  wire logic [DW-2:0] omega_i,
  output out_item_t          out_o
);

  localparam logic signed [DW:0] ONE_D = (DW+1)'(1 << FB);

  // per-stage control and shared data
  logic [1:0]             kind_q  [FEQ_LAT];
  logic                   fault_q [FEQ_LAT];
  dist_t                  r_q     [4];
  dist_arr_t              f_q     [6];
  logic signed [SQW-1:0]  uxx_q;
  logic signed [SQW-1:0]  uyy_q;
  logic signed [SQW:0]    u2_q;
  logic signed [2*DW-1:0] pxx;
  logic signed [2*DW-1:0] pyy;
  logic signed [DW:0]     onem;
  logic signed [DW:0]     om_s;
  dist_t                  post_q  [NDIR];

  assign pxx  = ux_i * ux_i;
  assign pyy  = uy_i * uy_i;
  assign onem = ONE_D - signed'({2'b00, omega_i});
  assign om_s = signed'({2'b00, omega_i});

  // control and shared terms move with the data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind_q[0]  <= kind_i;
      fault_q[0] <= fault_i;
      for (int s = 1; s < FEQ_LAT; s++) begin
        kind_q[s]  <= kind_q[s-1];
        fault_q[s] <= fault_q[s-1];
      end
      r_q[0] <= r_i;
      for (int s = 1; s < 4; s++) begin
        r_q[s] <= r_q[s-1];
      end
      f_q[0] <= f_i;
      for (int s = 1; s < 6; s++) begin
        f_q[s] <= f_q[s-1];
      end
      uxx_q <= pxx[2*DW-1:FB];
      uyy_q <= pyy[2*DW-1:FB];
      u2_q  <= (SQW+1)'(uxx_q) + (SQW+1)'(uyy_q);
    end
  end

  for (genvar i = 0; i < NDIR; i++) begin : g_lane
    localparam logic signed [1:0] DX = dir_x(i);
    localparam logic signed [1:0] DY = dir_y(i);
    localparam logic [RCW-1:0]    RC = is_diag(i) ? RECIP36 : RECIP9;

    logic signed [DW+1:0]   tx;
    logic signed [DW+1:0]   ty;
    logic signed [2*DW-1:0] psq;
    logic signed [SW-1:0]   psum;
    logic signed [2*DW-1:0] prp;
    logic signed [MW-1:0]   x5;
    logic [MW-1:0]          mag5;
    logic signed [SW-1:0]   q6;
    logic signed [SW-1:0]   blend;

    dist_t                  ud1_q;
    logic signed [SQW-1:0]  sq2_q;
    dist_t                  ud2_q;
    dist_t                  p3_q;
    logic signed [TW-1:0]   t4_q;
    logic [MW+RCW-1:0]      prod5_q;
    logic                   neg5_q;
    dist_t                  feq6_q;
    logic signed [2*DW:0]   a7_q;
    logic signed [2*DW:0]   b7_q;
    dist_t                  feq7_q;

    // projection of velocity on this direction
    assign tx = (DX == 2'sd1) ? (DW+2)'(ux_i) :
                (DX == -2'sd1) ? -(DW+2)'(ux_i) : '0;
    assign ty = (DY == 2'sd1) ? (DW+2)'(uy_i) :
                (DY == -2'sd1) ? -(DW+2)'(uy_i) : '0;

    assign psq  = ud1_q * ud1_q;
    assign psum = ONE_W + SW'(3) * SW'(ud2_q) + ((SW'(9) * SW'(sq2_q)) >>> 1)
                  - ((SW'(3) * SW'(u2_q)) >>> 1);
    assign prp  = r_q[2] * p3_q;
    assign x5   = is_rest(i) ? (MW'(t4_q) <<< 2) : MW'(t4_q);
    assign mag5 = x5[MW-1] ? (~x5 + MW'(1)) : x5;
    assign q6   = SW'(prod5_q >> RK);
    assign blend = (SW'(a7_q) + SW'(b7_q)) >>> FB;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        // stage 1: direction projection
        ud1_q   <= sat(SW'(tx + ty));
        // stage 2: square of the projection
        sq2_q   <= psq[2*DW-1:FB];
        ud2_q   <= ud1_q;
        // stage 3: polynomial in velocity
        p3_q    <= sat(psum);
        // stage 4: scale by density
        t4_q    <= prp[2*DW-1:FB];
        // stage 5: weight as a reciprocal multiply on the magnitude
        prod5_q <= mag5 * RC;
        neg5_q  <= x5[MW-1];
        // stage 6: restore sign
        feq6_q  <= sat(neg5_q ? -q6 : q6);
        // stage 7: relaxation products
        a7_q    <= onem * f_q[5][i];
        b7_q    <= om_s * feq6_q;
        feq7_q  <= feq6_q;
        // stage 8: pick by cell kind
        if (kind_q[6] == KIND_SOLID || kind_q[6] == KIND_INLET) begin
          post_q[i] <= feq7_q;
        end else begin
          post_q[i] <= sat(blend);
        end
      end
    end
  end

  assign out_o.post_0        = post_q[0];
  assign out_o.post_1        = post_q[1];
  assign out_o.post_2        = post_q[2];
  assign out_o.post_3        = post_q[3];
  assign out_o.post_4        = post_q[4];
  assign out_o.post_5        = post_q[5];
  assign out_o.post_6        = post_q[6];
  assign out_o.post_7        = post_q[7];
  assign out_o.post_8        = post_q[8];
  assign out_o.density_fault = fault_q[FEQ_LAT-1];

endmodule

`default_nettype wire

// ----- rtl/lbm_d2q9_bgk_collision_top.sv -----
// channel   | direction | payload     | handshake
// in        | into      | in_item_t   | in_valid_i / in_stall_o
// out       | out of    | out_item_t  | out_valid_o / out_stall_i
// cfg       | into      | 32-bit regs | apb psel / penable / pready
//
// one cell per cycle unless the output stalls; the stages are one moment stage,
// DW + 2 divider stages (one quotient bit each) and eight equilibrium stages.
// reset clears the valid bits and loads the register defaults; no clearing pass.
// a stalled valid output freezes the whole pipeline; bubbles travel as invalid slots.
// depends on lbm_pkg, lbm_apb, lbm_moments, lbm_div, lbm_feq
`default_nettype none

module lbm_d2q9_bgk_collision_top
  import lbm_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output out_item_t           out_data_o,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [AW-1:0]  paddr,
  input  wire logic [PDW-1:0] pwdata,
  output logic      [PDW-1:0] prdata,
  output logic                pready
);

  logic [PIPE_LAT-1:0] vld_q;
  logic                en;
  cfg_t                cfg;
  mom_t                mom;
  dist_arr_t           f0;
  mom_t                mom_dly_q [DIV_LAT];
  dist_arr_t           f_dly_q   [DIV_LAT];
  dist_t               qx;
  dist_t               qy;
  mom_t                md;
  dist_t               r_sel;
  dist_t               ux_sel;
  dist_t               uy_sel;

  // global advance
  assign en          = !(vld_q[PIPE_LAT-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[PIPE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_valid_i};
    end
  end

  lbm_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lbm_moments u_mom (
    .clk_i     (clk_i),
    .en_i      (en),
    .in_data_i (in_data_i),
    .mom_o     (mom),
    .f_o       (f0)
  );

  lbm_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (mom.jx),
    .den_i (mom.rho),
    .quo_o (qx)
  );

  lbm_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (mom.jy),
    .den_i (mom.rho),
    .quo_o (qy)
  );

  // cell data waits alongside the dividers
  always_ff @(posedge clk_i) begin
    if (en) begin
      mom_dly_q[0] <= mom;
      f_dly_q[0]   <= f0;
      for (int k = 1; k < DIV_LAT; k++) begin
        mom_dly_q[k] <= mom_dly_q[k-1];
        f_dly_q[k]   <= f_dly_q[k-1];
      end
    end
  end

  assign md = mom_dly_q[DIV_LAT-1];

  // equilibrium inputs by cell kind
  always_comb begin
    unique case (md.kind)
      KIND_SOLID: begin
        r_sel  = md.rho;
        ux_sel = '0;
        uy_sel = '0;
      end
      KIND_INLET: begin
        r_sel  = signed'({1'b0, cfg.inlet_density});
        ux_sel = cfg.inlet_velocity;
        uy_sel = '0;
      end
      default: begin
        r_sel  = md.rho;
        ux_sel = md.fault ? '0 : qx;
        uy_sel = md.fault ? '0 : qy;
      end
    endcase
  end

  lbm_feq u_feq (
    .clk_i   (clk_i),
    .en_i    (en),
    .r_i     (r_sel),
    .ux_i    (ux_sel),
    .uy_i    (uy_sel),
    .kind_i  (md.kind),
    .fault_i (md.fault),
    .f_i     (f_dly_q[DIV_LAT-1]),
    .omega_i (cfg.relax_rate),
    .out_o   (out_data_o)
  );

endmodule

`default_nettype wire

// ----- rtl/lbm_check.sv -----
// port-level checks for the collision block, bound to the top level
// depends on lbm_pkg and lbm_d2q9_bgk_collision_top
`default_nettype none

module lbm_check
  import lbm_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input out_item_t out_data_o
);

  // a held result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  // a held result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output payload changed while stalled");

  // input only stalls behind a blocked output
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked output");

  // pipeline empty right after reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind lbm_d2q9_bgk_collision_top lbm_check u_check (.*);

`default_nettype wire

// ----- tb/tb_lbm_d2q9_bgk_collision_top.sv -----
// testbench for the d2q9 bgk collision block: directed and random cells checked
// against an in-bench predictor; depends on lbm_pkg and lbm_d2q9_bgk_collision_top
`timescale 1ns / 1ps

module tb_lbm_d2q9_bgk_collision_top;
  import lbm_pkg::*;

  localparam longint CYCLE_LIMIT = 400000;
  localparam int SETTLE = 40;
  localparam int IW = $bits(in_item_t);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [PDW-1:0] pwdata = '0;
  logic [PDW-1:0] prdata;
  logic pready;

  lbm_d2q9_bgk_collision_top u_dut (.*);

  always #4 clk_i = ~clk_i;

  // predictor copy of the registers
  longint omega_q = 16384, inlet_rho_q = 16384, inlet_vel_q = 1638;

  in_item_t  cell_q [$];
  out_item_t post_q [$];
  int  errors = 0;
  bit  quiet = 1'b0;
  longint cycles = 0;

  function automatic longint clamp(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic longint floor_shr(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint feq_dir(longint r, longint ux, longint uy, int i);
    longint ud, sq, u2, p, t, num, den;
    ud = clamp(longint'(dir_x(i)) * ux + longint'(dir_y(i)) * uy);
    sq = floor_shr(ud * ud, FB);
    u2 = floor_shr(ux * ux, FB) + floor_shr(uy * uy, FB);
    p = clamp((64'sd1 <<< FB) + 3 * ud + floor_shr(9 * sq, 1) - floor_shr(3 * u2, 1));
    t = floor_shr(r * p, FB);
    num = (i == 0) ? 4 : 1;
    den = (i >= 5) ? 36 : 9;
    return clamp((t * num) / den);
  endfunction

  function automatic out_item_t collide(in_item_t c);
    longint f [9];
    longint rs, jxs, jys, r, jx, jy, ux, uy, v;
    logic [16*9-1:0] flat;
    out_item_t o;
    flat = c[145:2];
    rs = 0; jxs = 0; jys = 0; ux = 0; uy = 0;
    for (int i = 0; i < 9; i++) begin
      f[i] = longint'($signed(flat[16*(8-i) +: 16]));
      rs += f[i];
      jxs += longint'(dir_x(i)) * f[i];
      jys += longint'(dir_y(i)) * f[i];
    end
    r = clamp(rs); jx = clamp(jxs); jy = clamp(jys);
    if (r > 0) begin
      ux = clamp((jx <<< FB) / r);
      uy = clamp((jy <<< FB) / r);
    end
    for (int i = 0; i < 9; i++) begin
      if (c.cell_kind == KIND_SOLID) v = feq_dir(r, 0, 0, i);
      else if (c.cell_kind == KIND_INLET) v = feq_dir(inlet_rho_q, inlet_vel_q, 0, i);
      else v = clamp(floor_shr(((64'sd1 <<< FB) - omega_q) * f[i]
                               + omega_q * feq_dir(r, ux, uy, i), FB));
      flat[16*(8-i) +: 16] = v[15:0];
    end
    o = {flat, (r <= 0)};
    return o;
  endfunction

  // driver: one transaction per accepted cycle
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni) begin
      if (!in_valid_i || !in_stall_o) begin
        if (cell_q.size() > 0 && (quiet || $urandom_range(99) >= 7)) begin
          in_data_i <= cell_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !quiet && ($urandom_range(99) < 7);
    end
  end

  // monitor: predict on input acceptance, compare on output acceptance
  always @(posedge clk_i) begin
    out_item_t exp_o;
    if (rst_ni && in_valid_i && !in_stall_o) post_q.push_back(collide(in_data_i));
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (post_q.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, out_data_o);
        errors++;
      end else begin
        exp_o = post_q.pop_front();
        if (exp_o !== out_data_o) begin
          $display("%0t mismatch: expected %h, actual %h", $time, exp_o, out_data_o);
          errors++;
        end
      end
    end
  end

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= AW'({idx, 2'b00}); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_RELAX:     omega_q = val[14:0];
      REG_INLET_RHO: inlet_rho_q = val[14:0];
      default:       inlet_vel_q = longint'($signed(val[15:0]));
    endcase
  endtask

  task automatic drain();
    while (cell_q.size() > 0 || in_valid_i || post_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  function automatic in_item_t rand_cell(bit physical);
    in_item_t c;
    c = IW'({$urandom, $urandom, $urandom, $urandom, $urandom});
    if (physical) begin
      // realistic populations around rest, small perturbations
      c.dist_0 = 16'(7282 + $urandom_range(600) - 300);
      c.dist_1 = 16'(1820 + $urandom_range(600) - 300);
      c.dist_2 = 16'(1820 + $urandom_range(600) - 300);
      c.dist_3 = 16'(1820 + $urandom_range(600) - 300);
      c.dist_4 = 16'(1820 + $urandom_range(600) - 300);
      c.dist_5 = 16'(455 + $urandom_range(300) - 150);
      c.dist_6 = 16'(455 + $urandom_range(300) - 150);
      c.dist_7 = 16'(455 + $urandom_range(300) - 150);
      c.dist_8 = 16'(455 + $urandom_range(300) - 150);
    end
    c.cell_kind = 2'($urandom_range(3));
    return c;
  endfunction

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) cell_q.push_back(rand_cell($urandom_range(99) < 65));
    drain();
  endtask

  initial begin
    in_item_t c;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, every kind, zero and negative density
    for (int k = 0; k < 4; k++) begin
      c = '0; c.cell_kind = 2'(k); cell_q.push_back(c);
      c = {{9{16'sh7fff}}, 2'(k)}; cell_q.push_back(c);
      c = {{9{16'sh8000}}, 2'(k)}; cell_q.push_back(c);
      c = {16'sd4000, 16'sd3000, 16'sd0, -16'sd3000, 16'sd0,
           16'sd2000, -16'sd2000, -16'sd2000, 16'sd2000, 2'(k)};
      cell_q.push_back(c);
      cell_q.push_back(rand_cell(1'b1));
    end
    drain();
    random_phase(200);
    apb_write(REG_RELAX, 32'd32767);
    apb_write(REG_INLET_RHO, 32'd32767);
    apb_write(REG_INLET_VEL, 32'h8000);
    random_phase(200);
    apb_write(REG_RELAX, 32'd0);
    apb_write(REG_INLET_RHO, 32'd0);
    apb_write(REG_INLET_VEL, 32'h7fff);
    quiet = 1'b1;
    random_phase(150);
    quiet = 1'b0;
    apb_write(REG_RELAX, $urandom_range(32767));
    apb_write(REG_INLET_RHO, $urandom_range(32767));
    apb_write(REG_INLET_VEL, $urandom);
    random_phase(280);
    if (errors == 0) begin
      $display("tb_lbm_d2q9_bgk_collision_top: PASS");
    end else begin
      $display("tb_lbm_d2q9_bgk_collision_top: FAIL");
    end
    $finish;
  end

  // watchdog
  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_lbm_d2q9_bgk_collision_top: FAIL");
      $finish;
    end
  end

endmodule
